// File: rtl/qrs_pkg.sv
`timescale 1ns / 1ps

package qrs_pkg;

    // store geometry
    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // sample and fraction formats
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 19;
    localparam int Q_SHIFT     = 16;
    localparam int Q_ONE       = 1 << Q_SHIFT;
    localparam int CFG_IDX_W   = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_FRACTION = 1'b0,
        REG_UPPER_FRACTION = 1'b1
    } cfg_reg_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // write the request sample into the store
        logic close;      // latch the set size and restart the fill count
        logic calc_prod;  // register fraction times size products
        logic calc_idx;   // register the two target ranks, start first bit pass
        logic sweep;      // read the next store entry of the current pass
        logic decide;     // settle one key bit for both ranks
        logic emit;       // load the result registers
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic n_zero;     // closed set is empty
        logic last_addr;  // read address is at the last stored entry
        logic last_bit;   // current pass settles the lowest key bit
    } status_t;

endpackage

// File: rtl/qrs_ram.sv
`timescale 1ns / 1ps

module qrs_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/qrs_datapath.sv
`timescale 1ns / 1ps

module qrs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  qrs_pkg::cmd_t                       cmd,
    output qrs_pkg::status_t                    status,
    input  logic signed [qrs_pkg::DATA_W-1:0]   sample_value,
    input  logic                                cfg_write,
    input  logic [qrs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qrs_pkg::FRAC_W-1:0]          cfg_data,
    output logic signed [qrs_pkg::DATA_W-1:0]   low_bound_value,
    output logic signed [qrs_pkg::DATA_W-1:0]   high_bound_value,
    output logic                                empty_set,
    output logic [qrs_pkg::CNT_W-1:0]           set_size
);

    localparam int DW     = qrs_pkg::DATA_W;
    localparam int CW     = qrs_pkg::CNT_W;
    localparam int AW     = qrs_pkg::ADDR_W;
    localparam int FW     = qrs_pkg::FRAC_W;
    localparam int LO_W   = FW - 1;
    localparam int HI_W   = qrs_pkg::Q_SHIFT + 1;
    localparam int PLO_W  = LO_W + CW;
    localparam int PHI_W  = HI_W + CW;
    localparam int QW     = PLO_W - qrs_pkg::Q_SHIFT;
    localparam logic [DW-1:0] SIGN_BIT = {1'b1, {(DW-1){1'b0}}};

    // configuration
    logic signed [FW-1:0] lower_fraction_reg;
    logic signed [FW-1:0] upper_fraction_reg;

    // fill and set size
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_m1;
    logic          store_we;

    // index calculation
    logic [LO_W-1:0]  lo_clamp;
    logic [HI_W-1:0]  hi_clamp;
    logic             hi_nonpos;
    logic             hi_nonpos_reg;
    logic [PLO_W-1:0] prod_lo_reg;
    logic [PHI_W-1:0] prod_hi_reg;
    logic [QW-1:0]    lo_q;
    logic [QW-1:0]    hi_q;
    logic [QW-1:0]    hi_raw;
    logic [QW-1:0]    hi_max;
    logic [CW-1:0]    lo_idx;
    logic [CW-1:0]    hi_idx;

    // bitwise rank selection
    logic [CW-1:0] k_lo_reg;
    logic [CW-1:0] k_hi_reg;
    logic [CW-1:0] cnt_lo_reg;
    logic [CW-1:0] cnt_hi_reg;
    logic [DW-1:0] prefix_lo_reg;
    logic [DW-1:0] prefix_hi_reg;
    logic [DW-1:0] mask_reg;
    logic [DW-1:0] bit_reg;
    logic [AW-1:0] addr_reg;
    logic          rd_valid_reg;
    logic [DW-1:0] rd_data;
    logic [DW-1:0] key;
    logic          match_lo;
    logic          match_hi;

    // sample store
    qrs_ram #(
        .DATA_W (DW),
        .DEPTH  (qrs_pkg::MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (sample_value),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    // fill control, a full store drops further samples
    assign store_we   = cmd.load && (count_reg != CW'(qrs_pkg::MAX_SAMPLES));
    assign count_next = count_reg + CW'(store_we);
    assign n_m1       = n_reg - CW'(1);

    // clamped fractions
    assign lo_clamp  = lower_fraction_reg[FW-1] ? '0 : lower_fraction_reg[LO_W-1:0];
    assign hi_nonpos = upper_fraction_reg[FW-1] || (upper_fraction_reg == '0);
    assign hi_clamp  = (upper_fraction_reg > FW'(qrs_pkg::Q_ONE)) ?
                       HI_W'(qrs_pkg::Q_ONE) : upper_fraction_reg[HI_W-1:0];

    // ranks from the registered products
    assign lo_q   = prod_lo_reg[PLO_W-1:qrs_pkg::Q_SHIFT];
    assign hi_q   = QW'(prod_hi_reg[PHI_W-1:qrs_pkg::Q_SHIFT]);
    assign lo_idx = (lo_q > QW'(n_m1)) ? n_m1 : lo_q[CW-1:0];
    assign hi_raw = (hi_nonpos_reg || (hi_q == '0)) ? QW'(lo_idx) : hi_q - QW'(1);
    assign hi_max = (hi_raw < QW'(lo_idx)) ? QW'(lo_idx) : hi_raw;
    assign hi_idx = (hi_max > QW'(n_m1)) ? n_m1 : hi_max[CW-1:0];

    // order-preserving key and prefix match on the settled bits
    assign key      = rd_data ^ SIGN_BIT;
    assign match_lo = ((key & mask_reg) == prefix_lo_reg) && ((key & bit_reg) == '0);
    assign match_hi = ((key & mask_reg) == prefix_hi_reg) && ((key & bit_reg) == '0);

    assign status.n_zero    = (n_reg == '0);
    assign status.last_addr = ({1'b0, addr_reg} == n_m1);
    assign status.last_bit  = bit_reg[0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_fraction_reg <= '0;
            upper_fraction_reg <= FW'(qrs_pkg::Q_ONE);
        end
        else if (cfg_write)
        begin
            unique case (qrs_pkg::cfg_reg_t'(cfg_index))
                qrs_pkg::REG_LOWER_FRACTION: lower_fraction_reg <= cfg_data;
                qrs_pkg::REG_UPPER_FRACTION: upper_fraction_reg <= cfg_data;
            endcase
        end
    end

    // fill count, set size and read tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            n_reg        <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.sweep;
            if (cmd.close)
            begin
                n_reg     <= count_next;
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end
        end
    end

    // selection datapath
    always_ff @(posedge clk)
    begin
        if (cmd.calc_prod)
        begin
            prod_lo_reg   <= PLO_W'(lo_clamp) * PLO_W'(n_reg);
            prod_hi_reg   <= PHI_W'(hi_clamp) * PHI_W'(n_reg);
            hi_nonpos_reg <= hi_nonpos;
        end

        if (cmd.calc_idx)
        begin
            k_lo_reg      <= lo_idx;
            k_hi_reg      <= hi_idx;
            prefix_lo_reg <= '0;
            prefix_hi_reg <= '0;
            mask_reg      <= '0;
            bit_reg       <= SIGN_BIT;
            cnt_lo_reg    <= '0;
            cnt_hi_reg    <= '0;
            addr_reg      <= '0;
        end
        else if (cmd.decide)
        begin
            if (k_lo_reg >= cnt_lo_reg)
            begin
                k_lo_reg      <= k_lo_reg - cnt_lo_reg;
                prefix_lo_reg <= prefix_lo_reg | bit_reg;
            end
            if (k_hi_reg >= cnt_hi_reg)
            begin
                k_hi_reg      <= k_hi_reg - cnt_hi_reg;
                prefix_hi_reg <= prefix_hi_reg | bit_reg;
            end
            mask_reg   <= mask_reg | bit_reg;
            bit_reg    <= bit_reg >> 1;
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            if (cmd.sweep)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (rd_valid_reg && match_lo)
            begin
                cnt_lo_reg <= cnt_lo_reg + CW'(1);
            end
            if (rd_valid_reg && match_hi)
            begin
                cnt_hi_reg <= cnt_hi_reg + CW'(1);
            end
        end

        // result registers
        if (cmd.emit)
        begin
            if (status.n_zero)
            begin
                low_bound_value  <= '0;
                high_bound_value <= '0;
                empty_set        <= 1'b1;
                set_size         <= '0;
            end
            else
            begin
                low_bound_value  <= prefix_lo_reg ^ SIGN_BIT;
                high_bound_value <= prefix_hi_reg ^ SIGN_BIT;
                empty_set        <= 1'b0;
                set_size         <= n_reg;
            end
        end
    end

endmodule

// File: rtl/qrs_ctrl.sv
`timescale 1ns / 1ps

module qrs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             sample_present,
    input  logic             last_sample,
    input  qrs_pkg::status_t status,
    output qrs_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOSE,
        S_PROD,
        S_INDEX,
        S_SWEEP,
        S_DRAIN,
        S_DECIDE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load  = accept && sample_present;
                cmd.close = accept && last_sample;
                if (accept && last_sample)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                if (status.n_zero)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = S_INDEX;
            end
            S_INDEX:
            begin
                cmd.calc_idx = 1'b1;
                state_next   = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.last_bit ? S_FINISH : S_SWEEP;
            end
            S_FINISH:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.emit;
        end
    end

endmodule

// File: rtl/quantile_range_select_top.sv
`timescale 1ns / 1ps

// a request without last_sample leaves busy low and the next follows at once
// a request that closes an empty set goes through S_CLOSE, whose emit is registered into done
// otherwise the states run S_CLOSE, S_PROD, S_INDEX, then per key bit S_SWEEP, S_DRAIN, S_DECIDE, then S_FINISH:
// one pass over the single-read-port store per key bit settles both bounds
// rst_n clears the fill count and control and loads fractions 0 and 1.0; done is never stalled
module quantile_range_select_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qrs_pkg::DATA_W-1:0]   sample_value,
    input  logic                                sample_present,
    input  logic                                last_sample,
    output logic                                done,
    output logic signed [qrs_pkg::DATA_W-1:0]   low_bound_value,
    output logic signed [qrs_pkg::DATA_W-1:0]   high_bound_value,
    output logic                                empty_set,
    output logic [qrs_pkg::CNT_W-1:0]           set_size,
    input  logic                                cfg_write,
    input  logic [qrs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qrs_pkg::FRAC_W-1:0]          cfg_data
);

    qrs_pkg::cmd_t    cmd;
    qrs_pkg::status_t status;

    // sequencer
    qrs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .sample_present (sample_present),
        .last_sample    (last_sample),
        .status         (status),
        .cmd            (cmd),
        .busy           (busy),
        .done           (done)
    );

    // store, rank arithmetic and selection
    qrs_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .sample_value     (sample_value),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .low_bound_value  (low_bound_value),
        .high_bound_value (high_bound_value),
        .empty_set        (empty_set),
        .set_size         (set_size)
    );

    // a closing request always makes the block busy
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_sample) |=> busy)
        else $error("closing request did not start selection");

    // result comes out with the block ready for the next request
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // one cycle strobe per result
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    // empty result carries zero size and bounds
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && empty_set) |->
            ((set_size == '0) && (low_bound_value == '0) && (high_bound_value == '0)))
        else $error("empty result with nonzero fields");

endmodule

// File: bench/quantile_range_select_top_tb.sv
`timescale 1ns / 1ps

module quantile_range_select_top_tb;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 500;
    localparam int FRAC_MIN       = -131072;
    localparam int FRAC_MAX       = 131072;

    // one selection outcome as seen on the result ports
    typedef struct packed {
        logic signed [qrs_pkg::DATA_W-1:0] low_value;
        logic signed [qrs_pkg::DATA_W-1:0] high_value;
        logic                              empty;
        logic [qrs_pkg::CNT_W-1:0]         count;
    } bounds_t;

    // tracks the sample set and predicts the bounds of every closed set
    class bounds_scoreboard;
        int      lower_frac;
        int      upper_frac;
        int      store [qrs_pkg::MAX_SAMPLES];
        int      fill;
        bounds_t pending [$];
        int      mismatches;
        int      checked;
        int      requests;
        int      closed_sets;

        function new();
            lower_frac  = 0;
            upper_frac  = qrs_pkg::Q_ONE;
            fill        = 0;
            mismatches  = 0;
            checked     = 0;
            requests    = 0;
            closed_sets = 0;
        endfunction

        function void set_fraction(qrs_pkg::cfg_reg_t idx, logic [qrs_pkg::FRAC_W-1:0] raw);
            if (idx == qrs_pkg::REG_LOWER_FRACTION)
                lower_frac = int'($signed(raw));
            else
                upper_frac = int'($signed(raw));
        endfunction

        // accepted request: store the sample, on close predict the two bounds
        function void note_request(logic signed [qrs_pkg::DATA_W-1:0] value, logic present,
                                   logic last);
            bounds_t exp_bounds;
            int      n;
            int      lo;
            int      hi;
            int      lo_idx;
            int      hi_idx;
            int      key;
            int      j;

            requests++;
            if (present && fill < qrs_pkg::MAX_SAMPLES) begin
                store[fill] = value;
                fill++;
            end
            if (!last)
                return;

            closed_sets++;
            n    = fill;
            fill = 0;
            exp_bounds = '0;
            if (n == 0) begin
                exp_bounds.empty = 1'b1;
                pending.push_back(exp_bounds);
                return;
            end

            // ascending order of the stored set
            for (int i = 1; i < n; i++) begin
                key = store[i];
                j   = i;
                while (j > 0 && store[j-1] > key) begin
                    store[j] = store[j-1];
                    j--;
                end
                store[j] = key;
            end

            lo = (lower_frac < 0) ? 0 : lower_frac;
            hi = (upper_frac > qrs_pkg::Q_ONE) ? qrs_pkg::Q_ONE : upper_frac;

            lo_idx = (lo * n) >>> qrs_pkg::Q_SHIFT;
            if (lo_idx > n - 1)
                lo_idx = n - 1;

            hi_idx = (hi <= 0) ? -1 : ((hi * n) >>> qrs_pkg::Q_SHIFT) - 1;
            if (hi_idx < lo_idx)
                hi_idx = lo_idx;
            if (hi_idx > n - 1)
                hi_idx = n - 1;

            exp_bounds.low_value  = store[lo_idx];
            exp_bounds.high_value = store[hi_idx];
            exp_bounds.count      = n[qrs_pkg::CNT_W-1:0];
            pending.push_back(exp_bounds);
        endfunction

        // compare one result against the oldest predicted bounds
        function void check_result(bounds_t got);
            bounds_t exp_bounds;

            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result low=%0d high=%0d empty=%0b size=%0d",
                             $realtime, got.low_value, got.high_value, got.empty,
                             got.count);
                return;
            end
            exp_bounds = pending.pop_front();
            checked++;
            if (got.low_value !== exp_bounds.low_value
                    || got.high_value !== exp_bounds.high_value
                    || got.empty !== exp_bounds.empty
                    || got.count !== exp_bounds.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp low=%0d high=%0d empty=%0b size=%0d",
                             $realtime, exp_bounds.low_value, exp_bounds.high_value,
                             exp_bounds.empty, exp_bounds.count,
                             ", got low=%0d high=%0d empty=%0b size=%0d",
                             got.low_value, got.high_value, got.empty, got.count);
            end
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n          = 1'b0;
    logic                              start          = 1'b0;
    logic                              busy;
    logic signed [qrs_pkg::DATA_W-1:0] sample_value   = '0;
    logic                              sample_present = 1'b0;
    logic                              last_sample    = 1'b0;
    logic                              done;
    logic signed [qrs_pkg::DATA_W-1:0] low_bound_value;
    logic signed [qrs_pkg::DATA_W-1:0] high_bound_value;
    logic                              empty_set;
    logic [qrs_pkg::CNT_W-1:0]         set_size;
    logic                              cfg_write      = 1'b0;
    logic [qrs_pkg::CFG_IDX_W-1:0]     cfg_index      = '0;
    logic [qrs_pkg::FRAC_W-1:0]        cfg_data       = '0;

    bounds_scoreboard sb;
    int               idle_cycles;
    int               sent_items;
    int               cfg_writes;

    quantile_range_select_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .sample_value     (sample_value),
        .sample_present   (sample_present),
        .last_sample      (last_sample),
        .done             (done),
        .low_bound_value  (low_bound_value),
        .high_bound_value (high_bound_value),
        .empty_set        (empty_set),
        .set_size         (set_size),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result capture and watchdog on request or result activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result('{low_bound_value, high_bound_value, empty_set, set_size});
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request or result for %0d cycles", WATCHDOG_LIMIT);
                $display("quantile_range_select_top_tb failed");
                $finish;
            end
        end
    end

    // gap before a request: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // sample values biased toward duplicates and extremes
    function automatic logic signed [qrs_pkg::DATA_W-1:0] pick_sample();
        int r;
        r = $urandom_range(15);
        if (r < 4)
            return int'($urandom_range(6)) - 3;
        if (r == 4)
            return {1'b1, {(qrs_pkg::DATA_W-1){1'b0}}};
        if (r == 5)
            return {1'b0, {(qrs_pkg::DATA_W-1){1'b1}}};
        return $urandom;
    endfunction

    function automatic int pick_fraction();
        case ($urandom_range(7))
            0: return FRAC_MIN;
            1: return FRAC_MAX;
            2: return 0;
            3: return qrs_pkg::Q_ONE;
            default: return int'($urandom_range(FRAC_MAX - FRAC_MIN)) + FRAC_MIN;
        endcase
    endfunction

    // one request: hold start until accepted, then record it
    task automatic send_request(input logic signed [qrs_pkg::DATA_W-1:0] value,
                                input logic present, input logic last, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        sample_value   <= value;
        sample_present <= present;
        last_sample    <= last;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_request(value, present, last);
    endtask

    // wait until every predicted result has come and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fraction(input qrs_pkg::cfg_reg_t idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[qrs_pkg::FRAC_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_fraction(idx, value[qrs_pkg::FRAC_W-1:0]);
        cfg_writes++;
        @(posedge clk);
    endtask

    // one sample set with random content and stray markers
    task automatic run_set(input int n_present, input bit marker_close, input bit no_gaps);
        for (int i = 0; i < n_present; i++)
        begin
            if ($urandom_range(7) == 0)
            begin
                send_request(pick_sample(), 1'b0, 1'b0, no_gaps ? 0 : pick_gap());
                sent_items++;
            end
            send_request(pick_sample(), 1'b1, (i == n_present - 1) && !marker_close,
                         no_gaps ? 0 : pick_gap());
            sent_items++;
        end
        if (marker_close || n_present == 0)
        begin
            send_request(pick_sample(), 1'b0, 1'b1, no_gaps ? 0 : pick_gap());
            sent_items++;
        end
    endtask

    initial
    begin
        int  n;

        sb          = new();
        idle_cycles = 0;
        sent_items  = 0;
        cfg_writes  = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, single sample, then extremes with a stray marker
        send_request(32'sd9, 1'b0, 1'b1, 0);
        send_request({1'b1, {(qrs_pkg::DATA_W-1){1'b0}}}, 1'b1, 1'b1, 0);
        send_request({1'b0, {(qrs_pkg::DATA_W-1){1'b1}}}, 1'b1, 1'b0, 0);
        send_request(32'sd5, 1'b0, 1'b0, 1);
        send_request({1'b1, {(qrs_pkg::DATA_W-1){1'b0}}}, 1'b1, 1'b0, 0);
        send_request(32'sd0, 1'b1, 1'b0, 0);
        send_request(-32'sd1, 1'b1, 1'b1, 2);
        drain();

        // fractions beyond both clamps, set closed by a bare marker
        write_fraction(qrs_pkg::REG_LOWER_FRACTION, FRAC_MIN);
        write_fraction(qrs_pkg::REG_UPPER_FRACTION, FRAC_MAX);
        send_request(32'sd5, 1'b1, 1'b0, 0);
        send_request(-32'sd5, 1'b1, 1'b0, 0);
        send_request(32'sd0, 1'b1, 1'b0, 0);
        send_request(32'sd3, 1'b0, 1'b1, 0);
        drain();

        // lower above one saturates, upper at zero falls back to the low rank
        write_fraction(qrs_pkg::REG_LOWER_FRACTION, FRAC_MAX);
        write_fraction(qrs_pkg::REG_UPPER_FRACTION, 0);
        send_request(32'sd30, 1'b1, 1'b0, 0);
        send_request(32'sd10, 1'b1, 1'b0, 0);
        send_request(32'sd20, 1'b1, 1'b1, 0);
        drain();

        // lower at exactly one, upper at the negative FRAC_MIN
        write_fraction(qrs_pkg::REG_LOWER_FRACTION, qrs_pkg::Q_ONE);
        write_fraction(qrs_pkg::REG_UPPER_FRACTION, FRAC_MIN);
        send_request(-32'sd7, 1'b1, 1'b0, 0);
        send_request(32'sd7, 1'b1, 1'b1, 0);
        drain();

        // interior quantiles over a set with duplicates
        write_fraction(qrs_pkg::REG_LOWER_FRACTION, qrs_pkg::Q_ONE / 2);
        write_fraction(qrs_pkg::REG_UPPER_FRACTION, 3 * qrs_pkg::Q_ONE / 4);
        send_request(32'sd4, 1'b1, 1'b0, 0);
        send_request(32'sd4, 1'b1, 1'b0, 0);
        send_request(-32'sd2, 1'b1, 1'b0, 0);
        send_request(32'sd9, 1'b1, 1'b1, 0);
        drain();

        // random sets, mostly small, some of medium size
        while (sent_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(2) == 0)
            begin
                drain();
                if ($urandom_range(2) != 0)
                    write_fraction(qrs_pkg::REG_LOWER_FRACTION, pick_fraction());
                if ($urandom_range(2) != 0)
                    write_fraction(qrs_pkg::REG_UPPER_FRACTION, pick_fraction());
            end
            n = ($urandom_range(5) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
            run_set(n, $urandom_range(3) == 0, $urandom_range(3) == 0);
        end

        drain();
        repeat (40) @(posedge clk);

        if (sb.pending.size() != 0)
        begin
            $display("%0d predicted results never arrived", sb.pending.size());
            sb.mismatches += sb.pending.size();
        end

        $display("ran %0d requests in %0d sample sets with random gaps and stray markers",
                 sb.requests, sb.closed_sets);
        $display("checked %0d bound results over %0d fraction writes, %0d mismatches",
                 sb.checked, cfg_writes, sb.mismatches);
        if (sb.mismatches == 0)
            $display("quantile_range_select_top_tb passed");
        else
            $display("quantile_range_select_top_tb failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/qrs_pkg.sv
rtl/qrs_ram.sv
rtl/qrs_datapath.sv
rtl/qrs_ctrl.sv
rtl/quantile_range_select_top.sv
bench/quantile_range_select_top_tb.sv
